// ----- hdl/symmetric_3x3_convolution_unit_defines.svh -----
// assertion helpers for the convolution unit, sampled on clk, off while rst_n is low
`ifndef SYMMETRIC_3X3_CONVOLUTION_UNIT_DEFINES_SVH
`define SYMMETRIC_3X3_CONVOLUTION_UNIT_DEFINES_SVH

// condition must hold at every edge
`define SCONV_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent must hold at the same edge as the antecedent
`define SCONV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold at the edge after the antecedent
`define SCONV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sconv_pkg.sv -----
package sconv_pkg;

  localparam int COEF_W     = 16;
  localparam int DIM_W      = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_HORIZ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_VERT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_DIAG    = 3'd5;

  localparam logic [DIM_W-1:0]  WIDTH_RESET       = 11'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET      = 11'd480;
  localparam logic [COEF_W-1:0] COEF_CENTER_RESET = 16'h4000;

  localparam int DIM_MIN      = 3;
  localparam int HEIGHT_LIMIT = 1024;
  localparam int ROW_W        = 10;
  localparam int ROW_MAX      = 1023;

  localparam int VALUE_W = 21;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 21'sh0FFFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 21'sh100000;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  typedef struct packed {
    logic interior;
    logic last;
  } sconv_res_t;

endpackage

// ----- hdl/symmetric_3x3_convolution_unit.sv -----
// symmetric 3x3 convolution unit
// input channel: in_valid / in_stall with in_func (0 pixel, 1 flush) and in_pixel,
// pixels of one frame in raster order. result channel: out_valid / out_stall with
// out_value (signed, saturated) and out_last on the final pixel of the frame.
// each pixel leaves one line plus one pixel after it entered; a frame is finished
// by image_width+1 flush transactions. interior pixels get the weighted 3x3 sum,
// border pixels pass unchanged.
// throughput: one transaction per cycle in both directions unless in_stall or
// out_stall holds it. the mid line store is read and written once per item, the old
// store is read at the input and written later from the mid read; the arithmetic
// runs in a pipe of stages a to e, whose results collect in an 8-entry queue; when
// the receiver stalls the queue fills and in_stall rises once 8 results are
// outstanding, no data is dropped. every configuration write recomputes the output
// column/row from the output count with a bit-serial divider: in_stall is high
// while the pass after the last write runs. reset (synchronous, rst_n low) restores
// register defaults, clears counters, window and queue; line store contents stay
// undefined, which only ever feeds border outputs that do not read them.
`include "symmetric_3x3_convolution_unit_defines.svh"

module symmetric_3x3_convolution_unit #(
  parameter int MAX_WIDTH      = 1024,
  parameter int PIXEL_BITS     = 16,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [sconv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sconv_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_func,
  input  logic [PIXEL_BITS-1:0]                 in_pixel,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sconv_pkg::VALUE_W-1:0]  out_value,
  output logic                                  out_last
);
  import sconv_pkg::*;

  localparam int PB  = PIXEL_BITS;
  localparam int CW  = $clog2(MAX_WIDTH);                     // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);                 // clamped width
  localparam int XW  = WW + 1;                                // column compares
  localparam int OCW = $clog2(MAX_WIDTH * HEIGHT_LIMIT);      // output count
  localparam int TW  = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);  // pixels per frame
  localparam int YW  = OCW + 1;                               // row compares
  localparam int DCW = $clog2(OCW + 1);                       // divider steps
  localparam int PW  = COEF_W + PB + 3;                       // one product
  localparam int SW  = PW + 2;                                // sum of products
  localparam int RESET_W = (int'(WIDTH_RESET) > MAX_WIDTH) ? MAX_WIDTH : int'(WIDTH_RESET);
  localparam logic [TW-1:0] RESET_TOTAL = TW'(RESET_W * int'(HEIGHT_RESET));
  localparam logic signed [SW-1:0] RND_HALF    = SW'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [SW-1:0] RND_HALF_M1 = RND_HALF - SW'(1);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]         image_width_r, image_height_r;
  logic signed [COEF_W-1:0] coef_center_r, coef_horiz_r, coef_vert_r, coef_diag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
      coef_center_r  <= COEF_CENTER_RESET;
      coef_horiz_r   <= '0;
      coef_vert_r    <= '0;
      coef_diag_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data[DIM_W-1:0];
        CFG_COEF_CENTER:  coef_center_r  <= cfg_data;
        CFG_COEF_HORIZ:   coef_horiz_r   <= cfg_data;
        CFG_COEF_VERT:    coef_vert_r    <= cfg_data;
        CFG_COEF_DIAG:    coef_diag_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // out-of-range frame sizes are clamped, never rejected
  logic [WW-1:0]    w_c;
  logic [DIM_W-1:0] h_c;

  always_comb begin
    if (image_width_r < DIM_W'(DIM_MIN)) begin
      w_c = WW'(DIM_MIN);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(image_width_r);
    end
    if (image_height_r < DIM_W'(DIM_MIN)) begin
      h_c = DIM_W'(DIM_MIN);
    end else if (int'(image_height_r) > HEIGHT_LIMIT) begin
      h_c = DIM_W'(HEIGHT_LIMIT);
    end else begin
      h_c = image_height_r;
    end
  end

  // pixels per frame, registered; settles during the divider pass after a write
  logic [WW+DIM_W-1:0] total_full;
  logic [TW-1:0]       total_r;

  assign total_full = {{DIM_W{1'b0}}, w_c} * {{WW{1'b0}}, h_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= RESET_TOTAL;
    end else begin
      total_r <= total_full[TW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // position bookkeeping, all decided at the input transaction
  // ---------------------------------------------------------------------------
  logic             busy_r;
  logic [FIFO_CNT_W-1:0] cnt_r;   // results owed: in the pipe or in the queue
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [OCW-1:0]   oc_r, oc_nxt;
  logic [CW-1:0]    ox_r, ox_nxt;
  logic [OCW-1:0]   oy_r, oy_nxt;
  logic             acc, primed, col_wrap, ox_wrap, interior_now, last_now;
  logic [PB-1:0]    sample;

  assign in_stall = busy_r || (cnt_r >= FIFO_CNT_W'(FIFO_DEPTH));
  assign acc      = in_valid && !in_stall;
  assign sample   = in_func ? '0 : in_pixel;

  // first result once one line and one pixel are in
  assign primed   = (row_r >= ROW_W'(2)) || ((row_r == ROW_W'(1)) && (col_r != '0));
  assign col_wrap = (XW'(col_r) + XW'(1)) >= XW'(w_c);
  assign ox_wrap  = (XW'(ox_r) + XW'(1)) >= XW'(w_c);

  assign interior_now = (ox_r != '0) && ((XW'(ox_r) + XW'(2)) <= XW'(w_c)) &&
                        (oy_r != '0) && ((YW'(oy_r) + YW'(2)) <= YW'(h_c));
  assign last_now     = ((TW+1)'(oc_r) + (TW+1)'(1)) >= (TW+1)'(total_r);

  always_comb begin
    col_nxt = col_wrap ? '0 : col_r + CW'(1);
    row_nxt = row_r;
    if (col_wrap && (row_r < ROW_W'(ROW_MAX))) begin
      row_nxt = row_r + ROW_W'(1);
    end
    oc_nxt = oc_r;
    ox_nxt = ox_r;
    oy_nxt = oy_r;
    if (primed) begin
      if (last_now) begin
        // frame done: the next transaction opens a new frame
        col_nxt = '0;
        row_nxt = '0;
        oc_nxt  = '0;
        ox_nxt  = '0;
        oy_nxt  = '0;
      end else begin
        oc_nxt = oc_r + OCW'(1);
        if (ox_wrap) begin
          ox_nxt = '0;
          oy_nxt = oy_r + OCW'(1);
        end else begin
          ox_nxt = ox_r + CW'(1);
        end
      end
    end
  end

  // restoring divider: output column/row = output count divided by the width,
  // one quotient bit per cycle
  logic [DCW-1:0] div_cnt_r;
  logic [OCW-1:0] div_quo_r, div_quo_nxt;
  logic [WW-1:0]  div_rem_r, div_rem_nxt;
  logic [XW-1:0]  div_shift;
  logic           div_ge;

  assign div_shift   = {div_rem_r, div_quo_r[OCW-1]};
  assign div_ge      = div_shift >= XW'(w_c);
  assign div_rem_nxt = div_ge ? WW'(div_shift - XW'(w_c)) : WW'(div_shift);
  assign div_quo_nxt = {div_quo_r[OCW-2:0], div_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      div_cnt_r <= '0;
      div_quo_r <= '0;
      div_rem_r <= '0;
      col_r     <= '0;
      row_r     <= '0;
      oc_r      <= '0;
      ox_r      <= '0;
      oy_r      <= '0;
    end else if (cfg_we) begin
      // any write restarts the pass so it always sees the final width
      busy_r    <= 1'b1;
      div_cnt_r <= DCW'(OCW);
      div_quo_r <= oc_r;
      div_rem_r <= '0;
    end else if (busy_r) begin
      div_quo_r <= div_quo_nxt;
      div_rem_r <= div_rem_nxt;
      div_cnt_r <= div_cnt_r - DCW'(1);
      if (div_cnt_r == DCW'(1)) begin
        busy_r <= 1'b0;
        ox_r   <= div_rem_nxt[CW-1:0];
        oy_r   <= div_quo_nxt;
      end
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      oc_r  <= oc_nxt;
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // line stores: mid holds the previous line, old the one before
  // ---------------------------------------------------------------------------
  logic [PB-1:0] line_mid [MAX_WIDTH];
  logic [PB-1:0] line_old [MAX_WIDTH];
  logic [PB-1:0] rd_mid_r, rd_old_r, fwd_pix_r, up2;
  logic          fwd_r;

  // stage a
  logic          va_r, emita_r;
  sconv_res_t    resa_r;
  logic [CW-1:0] cola_r;
  logic [PB-1:0] samplea_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_mid_r         <= line_mid[col_r];
      line_mid[col_r]  <= sample;
    end
  end

  // old is refilled from the mid read while the item is in stage a; the item right behind
  // at the same column takes that value from the bypass
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_old_r <= line_old[col_r];
    end
    if (va_r) begin
      line_old[cola_r] <= rd_mid_r;
    end
  end

  assign up2 = fwd_r ? fwd_pix_r : rd_old_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      emita_r <= 1'b0;
    end else begin
      va_r    <= acc;
      emita_r <= acc && primed;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_r     <= va_r && (cola_r == col_r);
      fwd_pix_r <= rd_mid_r;
      cola_r    <= col_r;
      samplea_r <= sample;
      resa_r    <= '{interior: interior_now, last: last_now};
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: 3x3 window, shifts once per item whether or not it emits
  // ---------------------------------------------------------------------------
  logic [PB-1:0] win_r [3][3];
  logic          vb_r;
  sconv_res_t    resb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (va_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up2;
      win_r[1][2] <= rd_mid_r;
      win_r[2][2] <= samplea_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stages c..e: neighbor sums, products, total
  // ---------------------------------------------------------------------------
  logic                 vc_r, vd_r, ve_r;
  sconv_res_t           resc_r, resd_r, rese_r;
  logic [PB-1:0]        p_c_r, p_d_r, p_e_r;
  logic [PB:0]          hs_c_r, vs_c_r;
  logic [PB+1:0]        ds_c_r;
  logic signed [PW-1:0] cc_x, ch_x, cv_x, cd_x;
  logic signed [PW-1:0] prod_c_r, prod_h_r, prod_v_r, prod_d_r;
  logic signed [SW-1:0] sum_e_r;

  assign cc_x = PW'(coef_center_r);
  assign ch_x = PW'(coef_horiz_r);
  assign cv_x = PW'(coef_vert_r);
  assign cd_x = PW'(coef_diag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      vb_r <= va_r && emita_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    resb_r <= resa_r;
    if (vb_r) begin
      resc_r <= resb_r;
      p_c_r  <= win_r[1][1];
      hs_c_r <= {1'b0, win_r[1][0]} + {1'b0, win_r[1][2]};
      vs_c_r <= {1'b0, win_r[0][1]} + {1'b0, win_r[2][1]};
      ds_c_r <= {2'b00, win_r[0][0]} + {2'b00, win_r[0][2]}
              + {2'b00, win_r[2][0]} + {2'b00, win_r[2][2]};
    end
    if (vc_r) begin
      resd_r   <= resc_r;
      p_d_r    <= p_c_r;
      prod_c_r <= cc_x * $signed(PW'(p_c_r));
      prod_h_r <= ch_x * $signed(PW'(hs_c_r));
      prod_v_r <= cv_x * $signed(PW'(vs_c_r));
      prod_d_r <= cd_x * $signed(PW'(ds_c_r));
    end
    if (vd_r) begin
      rese_r  <= resd_r;
      p_e_r   <= p_d_r;
      sum_e_r <= SW'(prod_c_r) + SW'(prod_h_r) + SW'(prod_v_r) + SW'(prod_d_r);
    end
  end

  // final stage: round half away from zero, saturate, or pass the border pixel
  logic signed [SW-1:0]      rnd_sum, rnd_q, p_ext;
  logic signed [VALUE_W-1:0] fin_value;

  assign rnd_sum = sum_e_r + (sum_e_r[SW-1] ? RND_HALF_M1 : RND_HALF);
  assign rnd_q   = rnd_sum >>> COEF_FRAC_BITS;
  assign p_ext   = $signed(SW'(p_e_r));

  always_comb begin
    if (rese_r.interior) begin
      if (rnd_q > SW'(VALUE_MAX)) begin
        fin_value = VALUE_MAX;
      end else if (rnd_q < SW'(VALUE_MIN)) begin
        fin_value = VALUE_MIN;
      end else begin
        fin_value = rnd_q[VALUE_W-1:0];
      end
    end else begin
      fin_value = (p_ext > SW'(VALUE_MAX)) ? VALUE_MAX : p_ext[VALUE_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // result queue
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] fifo_val  [FIFO_DEPTH];
  logic                      fifo_last [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]     fcnt_r;
  logic                      fifo_rd;

  assign out_valid = fcnt_r != '0;
  assign out_value = fifo_val[rd_ptr_r];
  assign out_last  = fifo_last[rd_ptr_r];
  assign fifo_rd   = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (ve_r) begin
      fifo_val[wr_ptr_r]  <= fin_value;
      fifo_last[wr_ptr_r] <= rese_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (ve_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (fifo_rd) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      if (ve_r && !fifo_rd) begin
        fcnt_r <= fcnt_r + FIFO_CNT_W'(1);
      end else if (!ve_r && fifo_rd) begin
        fcnt_r <= fcnt_r - FIFO_CNT_W'(1);
      end
      if ((acc && primed) && !fifo_rd) begin
        cnt_r <= cnt_r + FIFO_CNT_W'(1);
      end else if (!(acc && primed) && fifo_rd) begin
        cnt_r <= cnt_r - FIFO_CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  logic [4:0] inflight;

  assign inflight = {va_r && emita_r, vb_r, vc_r, vd_r, ve_r};

  `SCONV_ASSERT_ALWAYS(a_owed_count,
    cnt_r == (fcnt_r + FIFO_CNT_W'($countones(inflight))),
    "owed result count disagrees with pipe and queue")
  `SCONV_ASSERT_SAME(a_queue_room, ve_r && !fifo_rd, fcnt_r < FIFO_CNT_W'(FIFO_DEPTH),
    "result written into a full queue")
  `SCONV_ASSERT_SAME(a_div_column, $fell(busy_r), XW'(ox_r) < XW'(w_c),
    "recomputed output column not below the width")
  `SCONV_ASSERT_NEXT(a_frame_end, acc && primed && last_now,
    (col_r == '0) && (row_r == '0) && (oc_r == '0),
    "position not cleared after the last pixel of a frame")

endmodule

// ----- dv/symmetric_3x3_convolution_unit_tb.sv -----
module symmetric_3x3_convolution_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sconv_pkg::*;

  localparam int LINE_DEPTH    = 1024;  // MAX_WIDTH of the dut
  localparam int FRAC_BITS     = 14;    // COEF_FRAC_BITS of the dut
  localparam int NUM_REGS      = 6;
  localparam int SETTLE_CYCLES = 16;    // result pipe plus margin
  localparam int RANDOM_ITEMS  = 2000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 100;

  localparam logic [NUM_REGS-1:0] ALL_REGS = '1;
  localparam longint VAL_HI = VALUE_MAX;
  localparam longint VAL_LO = VALUE_MIN;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } pixel_result_t;

  // dut ports, every input known from time zero
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  in_func   = 1'b0;
  logic [15:0]           in_pixel  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_value;
  logic                  out_last;

  // filter mirror: registers, line stores, window and raster counters
  logic [15:0]   shadow_regs [NUM_REGS];
  logic [15:0]   line_old [LINE_DEPTH];
  logic [15:0]   line_mid [LINE_DEPTH];
  logic [15:0]   window_px [3][3];
  int unsigned   col_count;
  int unsigned   row_count;
  int unsigned   out_count;
  bit            frame_done;

  pixel_result_t expected_pixels [$];

  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;

  // sender burst state and receiver stall pattern state
  int            burst_left = 0;
  int            stall_mode = 0;
  int            stall_span = 0;

  symmetric_3x3_convolution_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_last  (out_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("symmetric_3x3_convolution_unit_tb failed");
      $finish;
    end
  end

  // receiver stall pattern: spans of free flow, light, medium and heavy back-pressure
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(8, 64);
    end
    stall_span--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // every accepted result against the oldest expected pixel
  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result with nothing expected, value %0d last %0b",
                   $time, out_value, out_last);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_value !== want.value) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: out_value expected %0d got %0d",
                     $time, $signed(want.value), out_value);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: out_last expected %0b got %0b", $time, want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // effective frame size after clamping the registers
  function automatic int unsigned frame_width();
    int unsigned v;
    v = shadow_regs[CFG_IMAGE_WIDTH][DIM_W-1:0];
    if (v < DIM_MIN) v = DIM_MIN;
    if (v > LINE_DEPTH) v = LINE_DEPTH;
    return v;
  endfunction

  function automatic int unsigned frame_height();
    int unsigned v;
    v = shadow_regs[CFG_IMAGE_HEIGHT][DIM_W-1:0];
    if (v < DIM_MIN) v = DIM_MIN;
    if (v > HEIGHT_LIMIT) v = HEIGHT_LIMIT;
    return v;
  endfunction

  function automatic longint coef(input logic [CFG_IDX_W-1:0] idx);
    return longint'($signed(shadow_regs[idx]));
  endfunction

  // advance the mirror by one accepted transaction, queue the pixel it releases
  function automatic void predict_pixel(input logic func, input logic [15:0] pix);
    int unsigned   w, h, col, ox, oy;
    logic [15:0]   px_in, up2, up1;
    bit            primed, interior, last;
    longint        acc, mag, q, val;
    pixel_result_t res;
    w = frame_width();
    h = frame_height();
    px_in = func ? 16'd0 : pix;
    col = (col_count < LINE_DEPTH) ? col_count : LINE_DEPTH - 1;
    up2 = line_old[col];
    up1 = line_mid[col];
    line_old[col] = up1;
    line_mid[col] = px_in;
    for (int r = 0; r < 3; r++) begin
      window_px[r][0] = window_px[r][1];
      window_px[r][1] = window_px[r][2];
    end
    window_px[0][2] = up2;
    window_px[1][2] = up1;
    window_px[2][2] = px_in;

    // first output needs one line plus one pixel in the stores
    primed = (row_count >= 2) || (row_count == 1 && col_count >= 1);
    if (col_count + 1 >= w) begin
      col_count = 0;
      if (row_count < ROW_MAX) row_count++;
    end else begin
      col_count++;
    end
    if (!primed) return;

    ox = out_count % w;
    oy = out_count / w;
    interior = ox >= 1 && ox + 2 <= w && oy >= 1 && oy + 2 <= h;
    if (interior) begin
      acc = coef(CFG_COEF_CENTER) * longint'(window_px[1][1])
          + coef(CFG_COEF_HORIZ) * (longint'(window_px[1][0]) + longint'(window_px[1][2]))
          + coef(CFG_COEF_VERT) * (longint'(window_px[0][1]) + longint'(window_px[2][1]))
          + coef(CFG_COEF_DIAG) * (longint'(window_px[0][0]) + longint'(window_px[0][2])
                                 + longint'(window_px[2][0]) + longint'(window_px[2][2]));
      // round half away from zero on the magnitude
      mag = (acc < 0) ? -acc : acc;
      q = (mag + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      val = (acc < 0) ? -q : q;
    end else begin
      val = longint'(window_px[1][1]);
    end
    if (val > VAL_HI) val = VAL_HI;
    if (val < VAL_LO) val = VAL_LO;

    // an index at or past the frame size closes the frame too
    last = (out_count + 1 >= w * h);
    res.value = val[VALUE_W-1:0];
    res.last = last;
    expected_pixels.push_back(res);
    if (last) begin
      col_count = 0;
      row_count = 0;
      out_count = 0;
      frame_done = 1'b1;
    end else begin
      out_count++;
    end
  endfunction

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // one input transaction; the sender runs in bursts with random gaps
  task automatic send_item(input logic func, input logic [15:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func  <= func;
    in_pixel <= pix;
    do @(posedge clk); while (in_stall);
    predict_pixel(func, pix);
  endtask

  // flush transactions carry random payload, which the block ignores
  task automatic send_flush(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_item(1'b1, 16'($urandom));
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h);
    for (int unsigned i = 0; i < w * h; i++) send_item(1'b0, rand_pixel());
    send_flush(w + 1);
  endtask

  // idle the input, let every expected pixel arrive, then let the pipe drain
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic [NUM_REGS-1:0][15:0] vals,
                              input logic [NUM_REGS-1:0] mask);
    for (int i = 0; i < NUM_REGS; i++) begin
      if (mask[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_data  <= vals[i];
        @(posedge clk);
        shadow_regs[i] = vals[i];
      end
    end
    cfg_we <= 1'b0;
  endtask

  // reset width and identity center weight, then a shrink that closes the frame at once
  task automatic test_reset_config();
    logic [NUM_REGS-1:0][15:0] vals;
    logic [NUM_REGS-1:0]       mask;
    vals = '0;
    mask = '0;
    // one line plus one pixel primes the output, ten more pass row-zero pixels
    for (int i = 0; i < int'(WIDTH_RESET) + 11; i++) send_item(1'b0, rand_pixel());
    settle();
    vals[CFG_IMAGE_WIDTH]  = 16'd3;
    vals[CFG_IMAGE_HEIGHT] = 16'd3;
    mask[CFG_IMAGE_WIDTH]  = 1'b1;
    mask[CFG_IMAGE_HEIGHT] = 1'b1;
    apply_config(vals, mask);
    // output index already past 3x3, so the next result carries last
    send_item(1'b0, rand_pixel());
    // coefficients still at reset: interior equals center
    send_frame(3, 3);
  endtask

  // ties round away from zero, sums saturate at both ends
  task automatic test_rounding_saturation();
    logic [NUM_REGS-1:0][15:0] vals;
    logic [15:0]               px;
    int unsigned               row, col;
    settle();
    // center +1 LSB, horizontal -1 LSB in q2.14: results +0.5, -0.5 and -1.5
    vals = '0;
    vals[CFG_IMAGE_WIDTH]  = 16'd5;
    vals[CFG_IMAGE_HEIGHT] = 16'd3;
    vals[CFG_COEF_CENTER]  = 16'h0001;
    vals[CFG_COEF_HORIZ]   = 16'hFFFF;
    apply_config(vals, ALL_REGS);
    for (int unsigned i = 0; i < 15; i++) begin
      row = i / 5;
      col = i % 5;
      if (row == 1) begin
        px = (col == 1) ? 16'd8192 : (col == 4) ? 16'd24576 : 16'd0;
      end else begin
        px = ((col + row) % 2 == 0) ? 16'h0000 : 16'hFFFF;
      end
      send_item(1'b0, px);
    end
    send_flush(6);
    // all-max pixels with all weights at max, then at min
    for (int k = 0; k < 2; k++) begin
      settle();
      vals[CFG_IMAGE_WIDTH]  = 16'd3;
      vals[CFG_IMAGE_HEIGHT] = 16'd3;
      vals[CFG_COEF_CENTER]  = k ? 16'h8000 : 16'h7FFF;
      vals[CFG_COEF_HORIZ]   = k ? 16'h8000 : 16'h7FFF;
      vals[CFG_COEF_VERT]    = k ? 16'h8000 : 16'h7FFF;
      vals[CFG_COEF_DIAG]    = k ? 16'h8000 : 16'h7FFF;
      apply_config(vals, ALL_REGS);
      for (int i = 0; i < 9; i++) send_item(1'b0, 16'hFFFF);
      send_flush(4);
    end
  endtask

  // widest frame, then tallest; register values out of range and with masked high bits
  task automatic test_extreme_sizes();
    logic [NUM_REGS-1:0][15:0] vals;
    settle();
    vals[CFG_IMAGE_WIDTH]  = 16'h0400;
    vals[CFG_IMAGE_HEIGHT] = 16'hF800;  // low 11 bits zero, clamps to three lines
    vals[CFG_COEF_CENTER]  = rand_coef();
    vals[CFG_COEF_HORIZ]   = rand_coef();
    vals[CFG_COEF_VERT]    = rand_coef();
    vals[CFG_COEF_DIAG]    = rand_coef();
    apply_config(vals, ALL_REGS);
    send_frame(frame_width(), frame_height());
    settle();
    vals[CFG_IMAGE_WIDTH]  = 16'hF801;  // width one, clamps to three
    vals[CFG_IMAGE_HEIGHT] = 16'h07FF;  // clamps to 1024, row counter saturates
    vals[CFG_COEF_CENTER]  = rand_coef();
    vals[CFG_COEF_HORIZ]   = rand_coef();
    vals[CFG_COEF_VERT]    = rand_coef();
    vals[CFG_COEF_DIAG]    = rand_coef();
    apply_config(vals, ALL_REGS);
    send_frame(frame_width(), frame_height());
  endtask

  // registers rewritten in the middle of a frame: wider, narrower, and shorter than
  // the output index already reached
  task automatic test_reconfig_mid_frame();
    logic [NUM_REGS-1:0][15:0] vals;
    int unsigned first_w [3];
    int unsigned first_h [3];
    int unsigned lead_in [3];
    int unsigned next_w  [3];
    int unsigned next_h  [3];
    first_w = '{8, 12, 8};
    first_h = '{6, 5, 6};
    lead_in = '{30, 40, 40};
    next_w  = '{12, 5, 8};
    next_h  = '{4, 10, 3};
    for (int s = 0; s < 3; s++) begin
      settle();
      vals[CFG_IMAGE_WIDTH]  = 16'(first_w[s]);
      vals[CFG_IMAGE_HEIGHT] = 16'(first_h[s]);
      vals[CFG_COEF_CENTER]  = rand_coef();
      vals[CFG_COEF_HORIZ]   = rand_coef();
      vals[CFG_COEF_VERT]    = rand_coef();
      vals[CFG_COEF_DIAG]    = rand_coef();
      apply_config(vals, ALL_REGS);
      for (int unsigned i = 0; i < lead_in[s]; i++)
        send_item($urandom_range(0, 7) == 0, rand_pixel());
      settle();
      vals[CFG_IMAGE_WIDTH]  = 16'(next_w[s]);
      vals[CFG_IMAGE_HEIGHT] = 16'(next_h[s]);
      vals[CFG_COEF_CENTER]  = rand_coef();
      vals[CFG_COEF_HORIZ]   = rand_coef();
      vals[CFG_COEF_VERT]    = rand_coef();
      vals[CFG_COEF_DIAG]    = rand_coef();
      apply_config(vals, ALL_REGS);
      frame_done = 1'b0;
      while (!frame_done) send_item(1'b0, rand_pixel());
    end
  endtask

  // mostly well-formed frames of random size and weights; some flush transactions
  // inside a frame, some pixels in the tail, some frames cut short
  task automatic test_random_frames();
    logic [NUM_REGS-1:0][15:0] vals;
    logic [NUM_REGS-1:0]       mask;
    int unsigned               sent, w, h, n;
    logic                      func;
    sent = 0;
    mask = ALL_REGS;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: vals[CFG_IMAGE_WIDTH] = 16'($urandom_range(0, 2));
        1: vals[CFG_IMAGE_WIDTH] = 16'($urandom_range(13, 40));
        2: vals[CFG_IMAGE_WIDTH] = 16'hF800 | 16'($urandom_range(3, 12));
        default: vals[CFG_IMAGE_WIDTH] = 16'($urandom_range(3, 12));
      endcase
      vals[CFG_IMAGE_HEIGHT] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
                                                          : 16'($urandom_range(3, 7));
      vals[CFG_COEF_CENTER] = rand_coef();
      vals[CFG_COEF_HORIZ]  = rand_coef();
      vals[CFG_COEF_VERT]   = rand_coef();
      vals[CFG_COEF_DIAG]   = rand_coef();
      if (mask != '0) begin
        settle();
        apply_config(vals, mask);
      end
      w = frame_width();
      h = frame_height();
      n = w * h + w + 1;
      if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n - 1);
      for (int unsigned i = 0; i < n; i++) begin
        if (i < w * h) func = ($urandom_range(0, 19) == 0);
        else func = ($urandom_range(0, 4) != 0);
        send_item(func, rand_pixel());
        sent++;
      end
      // back-to-back frames without a register write now and then
      mask = ($urandom_range(0, 9) < 3) ? '0 : NUM_REGS'($urandom);
    end
  endtask

  initial begin
    shadow_regs[CFG_IMAGE_WIDTH]  = 16'(WIDTH_RESET);
    shadow_regs[CFG_IMAGE_HEIGHT] = 16'(HEIGHT_RESET);
    shadow_regs[CFG_COEF_CENTER]  = COEF_CENTER_RESET;
    shadow_regs[CFG_COEF_HORIZ]   = '0;
    shadow_regs[CFG_COEF_VERT]    = '0;
    shadow_regs[CFG_COEF_DIAG]    = '0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_old[i] = '0;
      line_mid[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) window_px[r][c] = '0;
    col_count  = 0;
    row_count  = 0;
    out_count  = 0;
    frame_done = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_config();
    test_rounding_saturation();
    test_extreme_sizes();
    test_reconfig_mid_frame();
    test_random_frames();
    settle();

    if (mismatch_count == 0) begin
      $display("symmetric_3x3_convolution_unit_tb passed");
    end else begin
      $display("symmetric_3x3_convolution_unit_tb failed");
    end
    $finish;
  end

endmodule
